/* rtl/assert_macros.svh */
// assertion helpers shared by the rtl modules
// each expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bdi_pkg.sv */
// ----------------------------------------------------------------------------
// bdi_pkg
// Shared types, codes and defaults of the bellows direction and intensity block.
// ----------------------------------------------------------------------------
package bdi_pkg;

  localparam int SUM_BITS_DEF   = 13;
  localparam int FULL_SCALE_DEF = 1024;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int CENTER_W   = 13;
  localparam int DEAD_W     = 12;
  localparam int HYST_W     = 12;
  localparam int FULL_W     = 13;
  localparam int SCALE_W    = 10;

  localparam logic [CENTER_W-1:0] CENTER_RST     = 13'd4096;
  localparam logic [DEAD_W-1:0]   DEAD_RST       = 12'd64;
  localparam logic [HYST_W-1:0]   HYST_RST       = 12'd16;
  localparam logic [FULL_W-1:0]   FULL_PUSH_RST  = 13'd1024;
  localparam logic [FULL_W-1:0]   FULL_PULL_RST  = 13'd7168;
  localparam logic [SCALE_W-1:0]  SCALE_MID_RST  = 10'd384;
  localparam logic [SCALE_W-1:0]  SCALE_HIGH_RST = 10'd512;

  localparam logic [SCALE_W-1:0] Q8_UNITY = 10'd256;
  localparam int                 Q8_SHIFT = 8;

  localparam logic [1:0] SENS_MID  = 2'd1;
  localparam logic [1:0] SENS_HIGH = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER     = 3'd0,
    REG_DEAD       = 3'd1,
    REG_HYST       = 3'd2,
    REG_FULL_PUSH  = 3'd3,
    REG_FULL_PULL  = 3'd4,
    REG_SCALE_MID  = 3'd5,
    REG_SCALE_HIGH = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    DIR_NEUTRAL = 2'd0,
    DIR_PUSH    = 2'd1,
    DIR_PULL    = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    INT_ZERO = 2'd0,
    INT_FULL = 2'd1,
    INT_DIV  = 2'd2
  } inten_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_CLASS = 3'd1,
    ST_DIV   = 3'd2,
    ST_MULT  = 3'd3,
    ST_WRITE = 3'd4
  } state_t;

  typedef struct packed {
    logic load_in;
    logic classify;
    logic mult;
    logic write_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_busy;
    logic div_last;
    logic out_free;
  } dp_sts_t;

endpackage

/* rtl/bdi_ctrl.sv */
// ----------------------------------------------------------------------------
// bdi_ctrl
// Sequencer: accept, classify, divide when needed, scale, write to the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bdi_ctrl import bdi_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output ctrl_cmd_t  cmd,
  input  dp_sts_t    sts
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_CLASS;
      end
      ST_CLASS: begin
        state_nxt = sts.need_div ? ST_DIV : ST_MULT;
      end
      ST_DIV: begin
        if (sts.div_last) state_nxt = ST_MULT;
      end
      ST_MULT: begin
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        // no beat is taken while reset is held
        in_tready   = rst_n;
        cmd.load_in = in_tvalid && rst_n;
      end
      ST_CLASS: begin
        cmd.classify = 1'b1;
      end
      ST_MULT: begin
        cmd.mult = 1'b1;
      end
      ST_WRITE: begin
        cmd.write_out = sts.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  `ASSERT_SAME(a_div_only_in_div, sts.div_busy, state_r == ST_DIV, "divider busy outside divide step")
  `ASSERT_NEXT(a_accept_to_class, in_tvalid && in_tready, state_r == ST_CLASS, "accepted beat not classified")
  `ASSERT_NEXT(a_div_holds, (state_r == ST_DIV) && !sts.div_last, state_r == ST_DIV, "left divide early")

endmodule

/* rtl/bdi_div.sv */
// ----------------------------------------------------------------------------
// bdi_div
// Restoring divider, one quotient bit per cycle; quotient known below 2**QB.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bdi_div import bdi_pkg::*; #(
  parameter int DW = 15,
  parameter int QB = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DW+QB-1:0] numer,
  input  logic [DW-1:0]    divisor,
  output logic             busy,
  output logic             last,
  output logic [QB-1:0]    quot
);

  localparam int CW = $clog2(QB);

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] div_r;
  logic [QB-1:0] low_r;
  logic [QB-1:0] quot_r;

  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        ge;

  assign trial = {rem_r, low_r[QB-1]};
  assign diff  = trial - {1'b0, div_r};
  assign ge    = trial >= {1'b0, div_r};
  assign last  = busy_r && (cnt_r == CW'(QB - 1));
  assign busy  = busy_r;
  assign quot  = quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (last) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= numer[DW+QB-1:QB];
      low_r  <= numer[QB-1:0];
      div_r  <= divisor;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[DW-1:0] : trial[DW-1:0];
      low_r  <= {low_r[QB-2:0], 1'b0};
      quot_r <= {quot_r[QB-2:0], ge};
    end
  end

  `ASSERT_NEXT(a_rem_below_div, busy_r, rem_r < div_r, "partial remainder not below divisor")

endmodule

/* rtl/bdi_datapath.sv */
// ----------------------------------------------------------------------------
// bdi_datapath
// Settings registers, direction state, classifier, divider, scaler and the
// output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bdi_datapath import bdi_pkg::*; #(
  parameter int SUM_BITS   = SUM_BITS_DEF,
  parameter int FULL_SCALE = FULL_SCALE_DEF,
  parameter int IW         = $clog2(FULL_SCALE + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctrl_cmd_t             cmd,
  output dp_sts_t               sts,
  input  logic [SUM_BITS-1:0]   in_hall_sum,
  input  logic [1:0]            in_sens_level,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [1:0]            out_direction,
  output logic [IW-1:0]         out_intensity
);

  localparam int EW = ((SUM_BITS > CENTER_W) ? SUM_BITS : CENTER_W) + 3;
  localparam int DW = EW - 1;
  localparam int QB = $clog2(FULL_SCALE);
  localparam int NW = DW + QB;
  localparam int PW = IW + SCALE_W;

  // settings
  logic [CENTER_W-1:0] center_r;
  logic [DEAD_W-1:0]   dead_r;
  logic [HYST_W-1:0]   hyst_r;
  logic [FULL_W-1:0]   full_push_r;
  logic [FULL_W-1:0]   full_pull_r;
  logic [SCALE_W-1:0]  scale_mid_r;
  logic [SCALE_W-1:0]  scale_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r     <= CENTER_RST;
      dead_r       <= DEAD_RST;
      hyst_r       <= HYST_RST;
      full_push_r  <= FULL_PUSH_RST;
      full_pull_r  <= FULL_PULL_RST;
      scale_mid_r  <= SCALE_MID_RST;
      scale_high_r <= SCALE_HIGH_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CENTER:     center_r     <= cfg_data[CENTER_W-1:0];
        REG_DEAD:       dead_r       <= cfg_data[DEAD_W-1:0];
        REG_HYST:       hyst_r       <= cfg_data[HYST_W-1:0];
        REG_FULL_PUSH:  full_push_r  <= cfg_data[FULL_W-1:0];
        REG_FULL_PULL:  full_pull_r  <= cfg_data[FULL_W-1:0];
        REG_SCALE_MID:  scale_mid_r  <= cfg_data[SCALE_W-1:0];
        REG_SCALE_HIGH: scale_high_r <= cfg_data[SCALE_W-1:0];
        default:        center_r     <= center_r;
      endcase
    end
  end

  // input item
  logic [SUM_BITS-1:0] hall_r;
  logic [1:0]          sens_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      hall_r <= in_hall_sum;
      sens_r <= in_sens_level;
    end
  end

  // classification
  logic signed [EW-1:0] v_s;
  logic signed [EW-1:0] push_lim;
  logic signed [EW-1:0] pull_lim;
  logic signed [EW-1:0] hyst_s;
  logic signed [EW-1:0] d_c;
  logic signed [EW-1:0] span_c;
  dir_t                 dir_r;
  dir_t                 dir_c;
  inten_mode_t          mode_c;
  inten_mode_t          mode_r;

  assign v_s      = EW'(hall_r);
  assign hyst_s   = EW'(hyst_r);
  assign push_lim = EW'(center_r) - EW'(dead_r);
  assign pull_lim = EW'(center_r) + EW'(dead_r);

  always_comb begin
    case (dir_r)
      DIR_PUSH: dir_c = (v_s >= push_lim + hyst_s) ? DIR_NEUTRAL : DIR_PUSH;
      DIR_PULL: dir_c = (v_s <= pull_lim - hyst_s) ? DIR_NEUTRAL : DIR_PULL;
      default: begin
        if (v_s < push_lim)      dir_c = DIR_PUSH;
        else if (v_s > pull_lim) dir_c = DIR_PULL;
        else                     dir_c = DIR_NEUTRAL;
      end
    endcase
  end

  always_comb begin
    case (dir_c)
      DIR_PUSH: begin
        d_c    = push_lim - v_s;
        span_c = push_lim - EW'(full_push_r);
      end
      DIR_PULL: begin
        d_c    = v_s - pull_lim;
        span_c = EW'(full_pull_r) - pull_lim;
      end
      default: begin
        d_c    = '0;
        span_c = '0;
      end
    endcase
  end

  // non-positive span saturates before the inside-band check
  always_comb begin
    if (dir_c == DIR_NEUTRAL)                                  mode_c = INT_ZERO;
    else if (span_c[EW-1] || span_c == '0 || d_c >= span_c)    mode_c = INT_FULL;
    else if (d_c[EW-1] || d_c == '0)                           mode_c = INT_ZERO;
    else                                                       mode_c = INT_DIV;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= DIR_NEUTRAL;
    end else if (cmd.classify) begin
      dir_r <= dir_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.classify) mode_r <= mode_c;
  end

  // distance * FULL_SCALE / span
  logic [NW-1:0] numer;
  logic [QB-1:0] quot;
  logic          div_busy;
  logic          div_last;

  assign numer = NW'(d_c[DW-1:0]) * NW'(FULL_SCALE);

  bdi_div #(
    .DW(DW),
    .QB(QB)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.classify && (mode_c == INT_DIV)),
    .numer   (numer),
    .divisor (span_c[DW-1:0]),
    .busy    (div_busy),
    .last    (div_last),
    .quot    (quot)
  );

  // q8 scaling
  logic [IW-1:0]      inten_sel;
  logic [SCALE_W-1:0] scale_sel;
  logic [PW-1:0]      prod_r;
  logic [PW-1:0]      shifted;
  logic [IW-1:0]      clamped;

  always_comb begin
    case (mode_r)
      INT_FULL: inten_sel = IW'(FULL_SCALE);
      INT_DIV:  inten_sel = IW'(quot);
      default:  inten_sel = '0;
    endcase
    case (sens_r)
      SENS_MID:  scale_sel = scale_mid_r;
      SENS_HIGH: scale_sel = scale_high_r;
      default:   scale_sel = Q8_UNITY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mult) prod_r <= PW'(inten_sel) * PW'(scale_sel);
  end

  assign shifted = prod_r >> Q8_SHIFT;
  assign clamped = (shifted > PW'(FULL_SCALE)) ? IW'(FULL_SCALE) : shifted[IW-1:0];

  // output register
  logic          out_valid_r;
  logic [1:0]    out_dir_r;
  logic [IW-1:0] out_inten_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.write_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_out) begin
      out_dir_r   <= dir_r;
      out_inten_r <= clamped;
    end
  end

  assign out_tvalid    = out_valid_r;
  assign out_direction = out_dir_r;
  assign out_intensity = out_inten_r;

  assign sts.need_div = (mode_c == INT_DIV);
  assign sts.div_busy = div_busy;
  assign sts.div_last = div_last;
  assign sts.out_free = !out_valid_r || out_tready;

  `ASSERT_SAME(a_inten_clamped, out_valid_r, out_inten_r <= IW'(FULL_SCALE), "intensity above full scale")

endmodule

/* rtl/bellows_direction_intensity.sv */
// ----------------------------------------------------------------------------
// bellows_direction_intensity
// Deadzone and hysteresis direction classifier with a scaled intensity.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+--------------------------------
//   in      | in  | in_tvalid/in_tready  | in_tdata: hall_sum, sens_level
//   out     | out | out_tvalid/out_tready| out_tdata: direction, intensity
//   cfg     | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// An item passes from accept through the classify, multiply and write steps to
// out_tvalid; when a division is needed the one-bit-per-cycle restoring divider
// runs between classify and multiply. The next item is accepted in the cycle
// after the result enters the output register.
// Reset (synchronous) loads the register defaults and a neutral direction.
// A result waiting in the output register does not block the next accept; a
// second result stalls in its write step until the first beat is taken.
// ----------------------------------------------------------------------------
module bellows_direction_intensity import bdi_pkg::*; #(
  parameter int SUM_BITS   = SUM_BITS_DEF,
  parameter int FULL_SCALE = FULL_SCALE_DEF,
  parameter int IW         = $clog2(FULL_SCALE + 1),
  parameter int IN_W       = ((SUM_BITS + 2 + 7) / 8) * 8,
  parameter int OUT_W      = ((2 + IW + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,    // hall_sum, sens_level, zero pad
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata,   // direction, intensity, zero pad
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t     cmd;
  dp_sts_t       sts;
  logic [1:0]    direction;
  logic [IW-1:0] intensity;

  assign cfg_ready = rst_n;
  assign out_tdata = OUT_W'({intensity, direction});

  bdi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  bdi_datapath #(
    .SUM_BITS   (SUM_BITS),
    .FULL_SCALE (FULL_SCALE),
    .IW         (IW)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_hall_sum   (in_tdata[SUM_BITS-1:0]),
    .in_sens_level (in_tdata[SUM_BITS+1:SUM_BITS]),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_direction (direction),
    .out_intensity (intensity)
  );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bellows direction and intensity block. A queue
// of hall readings feeds a stream driver and a monitor predicts every result
// from a mirror of the registers and the direction. Each result beat is
// checked field by field against the oldest prediction, across directed edge
// cases and random settings, under random idling and long output stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import bdi_pkg::*;

  localparam int IN_W        = 16;
  localparam int OUT_W       = 16;
  localparam int IW          = 11;
  localparam int MAX_READING = 8190;
  localparam int SETTLE_CYC  = 24;
  localparam int HOLD_CYC    = 300;
  localparam int RAND_PHASES = 8;
  localparam int HALF_ITEMS  = 50;
  localparam int MAX_PRINTS  = 40;

  // index past the last register, writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // register setting styles for the random phases
  localparam int SET_SANE = 0;
  localparam int SET_WILD = 1;
  localparam int SET_EDGE = 2;

  typedef struct packed {
    logic [SUM_BITS_DEF-1:0] hall;
    logic [1:0]              lvl;
  } hall_reading_t;

  typedef struct packed {
    dir_t          dir;
    logic [IW-1:0] inten;
  } bellows_res_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // register mirror and direction of the predictor
  logic [CENTER_W-1:0] m_center    = CENTER_RST;
  logic [DEAD_W-1:0]   m_dead      = DEAD_RST;
  logic [HYST_W-1:0]   m_hyst      = HYST_RST;
  logic [FULL_W-1:0]   m_full_push = FULL_PUSH_RST;
  logic [FULL_W-1:0]   m_full_pull = FULL_PULL_RST;
  logic [SCALE_W-1:0]  m_scale_mid = SCALE_MID_RST;
  logic [SCALE_W-1:0]  m_scale_hi  = SCALE_HIGH_RST;
  dir_t                m_dir       = DIR_NEUTRAL;

  hall_reading_t hall_reading_q[$];
  bellows_res_t  due_bellows_q[$];

  int n_sent = 0;
  int n_taken = 0;
  int n_results = 0;
  int n_push = 0;
  int n_pull = 0;
  int n_cfg = 0;
  int n_settings = 0;
  int err_cnt = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_reqs = 0;
  int hold_done = 0;
  int hold_left = 0;

  always #5 clk = ~clk;

  bellows_direction_intensity i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  function automatic longint travel_frac(input longint past, input longint span);
    if (span <= 0 || past >= span) return FULL_SCALE_DEF;
    if (past <= 0) return 0;
    return (past * FULL_SCALE_DEF) / span;
  endfunction

  // classify one reading, advance the direction, return direction and intensity
  function automatic bellows_res_t classify_bellows(input hall_reading_t rd);
    longint v, c, dz, hy, fp, fl, pe, ple, mag, scl, scaled;
    dir_t nd;
    bellows_res_t r;
    v   = rd.hall;
    c   = m_center;
    dz  = m_dead;
    hy  = m_hyst;
    fp  = m_full_push;
    fl  = m_full_pull;
    pe  = c - dz;
    ple = c + dz;
    case (m_dir)
      DIR_PUSH: nd = (v >= pe + hy) ? DIR_NEUTRAL : DIR_PUSH;
      DIR_PULL: nd = (v <= ple - hy) ? DIR_NEUTRAL : DIR_PULL;
      default: begin
        if (v < pe) nd = DIR_PUSH;
        else if (v > ple) nd = DIR_PULL;
        else nd = DIR_NEUTRAL;
      end
    endcase
    m_dir = nd;
    if (nd == DIR_PUSH) mag = travel_frac(pe - v, pe - fp);
    else if (nd == DIR_PULL) mag = travel_frac(v - ple, fl - ple);
    else mag = 0;
    if (rd.lvl == SENS_MID) scl = m_scale_mid;
    else if (rd.lvl == SENS_HIGH) scl = m_scale_hi;
    else scl = Q8_UNITY;
    scaled = (mag * scl) >>> Q8_SHIFT;
    if (scaled > FULL_SCALE_DEF) scaled = FULL_SCALE_DEF;
    r.dir   = nd;
    r.inten = scaled[IW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (err_cnt < MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, what);
    err_cnt++;
  endtask

  // input driver: holds a beat until taken, else offers the next reading or idles
  always @(negedge clk) begin
    hall_reading_t rd;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && n_sent != n_taken) begin
      in_tvalid <= 1'b1;
    end else if (hall_reading_q.size() != 0 && $urandom_range(99) >= send_idle) begin
      rd = hall_reading_q.pop_front();
      in_tdata  <= {1'b0, rd.lvl, rd.hall};
      in_tvalid <= 1'b1;
      n_sent++;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // output side: random back-pressure plus requested long hold-offs
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_reqs != hold_done) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYC;
      hold_done  <= hold_done + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor: predicts on input beats, checks result beats, mirrors register writes
  always @(posedge clk) begin
    hall_reading_t rd;
    bellows_res_t  want;
    logic [1:0]    got_dir;
    logic [IW-1:0] got_int;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        rd.hall = in_tdata[SUM_BITS_DEF-1:0];
        rd.lvl  = in_tdata[SUM_BITS_DEF+1:SUM_BITS_DEF];
        due_bellows_q.push_back(classify_bellows(rd));
        n_taken++;
      end
      if (out_tvalid && out_tready) begin
        got_dir = out_tdata[1:0];
        got_int = out_tdata[IW+1:2];
        n_results++;
        if (got_dir == DIR_PUSH) n_push++;
        if (got_dir == DIR_PULL) n_pull++;
        if (due_bellows_q.size() == 0) begin
          report_mismatch($sformatf("result beat dir %0d int %0d with nothing pending",
                                    got_dir, got_int));
        end else begin
          want = due_bellows_q.pop_front();
          if (got_dir != want.dir)
            report_mismatch($sformatf("result %0d direction got %0d want %0d",
                                      n_results, got_dir, want.dir));
          if (got_int != want.inten)
            report_mismatch($sformatf("result %0d intensity got %0d want %0d",
                                      n_results, got_int, want.inten));
        end
      end
      if (cfg_valid && cfg_ready) begin
        n_cfg++;
        case (cfg_index)
          REG_CENTER:     m_center    = cfg_data[CENTER_W-1:0];
          REG_DEAD:       m_dead      = cfg_data[DEAD_W-1:0];
          REG_HYST:       m_hyst      = cfg_data[HYST_W-1:0];
          REG_FULL_PUSH:  m_full_push = cfg_data[FULL_W-1:0];
          REG_FULL_PULL:  m_full_pull = cfg_data[FULL_W-1:0];
          REG_SCALE_MID:  m_scale_mid = cfg_data[SCALE_W-1:0];
          REG_SCALE_HIGH: m_scale_hi  = cfg_data[SCALE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  task automatic add_reading(input int hall, input int lvl);
    hall_reading_t rd;
    rd.hall = hall[SUM_BITS_DEF-1:0];
    rd.lvl  = lvl[1:0];
    hall_reading_q.push_back(rd);
  endtask

  task automatic wait_drained();
    while (hall_reading_q.size() != 0 || n_sent != n_taken || due_bellows_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic release_cfg();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(input int kind);
    int c, dz, hy, fp, fl, sm, sh;
    case (kind)
      SET_SANE: begin
        c  = $urandom_range(7500, 600);
        dz = $urandom_range(400, 0);
        hy = $urandom_range(200, 0);
        fp = $urandom_range(c - dz, 0);
        fl = $urandom_range(MAX_READING, c + dz);
        sm = $urandom_range(1023, 0);
        sh = $urandom_range(1023, 0);
      end
      SET_WILD: begin
        c  = $urandom_range(MAX_READING, 0);
        dz = $urandom_range(4095, 0);
        hy = $urandom_range(4095, 0);
        fp = $urandom_range(MAX_READING, 0);
        fl = $urandom_range(MAX_READING, 0);
        sm = $urandom_range(1023, 0);
        sh = $urandom_range(1023, 0);
      end
      default: begin
        c  = $urandom_range(1) ? MAX_READING : 0;
        dz = $urandom_range(1) ? 4095 : 0;
        hy = $urandom_range(1) ? 4095 : 0;
        fp = $urandom_range(1) ? MAX_READING : 0;
        fl = $urandom_range(1) ? MAX_READING : 0;
        sm = $urandom_range(1) ? 1023 : 0;
        sh = $urandom_range(1) ? 1023 : 0;
      end
    endcase
    write_reg(REG_CENTER, c);
    write_reg(REG_DEAD, dz);
    write_reg(REG_HYST, hy);
    write_reg(REG_FULL_PUSH, fp);
    write_reg(REG_FULL_PULL, fl);
    write_reg(REG_SCALE_MID, sm);
    write_reg(REG_SCALE_HIGH, sh);
    release_cfg();
    n_settings++;
  endtask

  // mostly readings near the edges, hysteresis points and full travel
  task automatic add_random_readings(input int count);
    int pts[7];
    int p;
    for (int k = 0; k < count; k++) begin
      pts[0] = int'(m_center) - int'(m_dead);
      pts[1] = pts[0] + int'(m_hyst);
      pts[2] = int'(m_center) + int'(m_dead);
      pts[3] = pts[2] - int'(m_hyst);
      pts[4] = m_full_push;
      pts[5] = m_full_pull;
      pts[6] = m_center;
      if ($urandom_range(99) < 35) begin
        p = $urandom_range(MAX_READING, 0);
      end else begin
        p = pts[$urandom_range(6, 0)] + int'($urandom_range(20, 0)) - 10;
        if (p < 0) p = 0;
        if (p > MAX_READING) p = MAX_READING;
      end
      add_reading(p, $urandom_range(3, 0));
    end
  endtask

  initial begin
    send_idle = 28;
    recv_idle = 57;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // defaults: push edge 4032, pull edge 4160, hysteresis 16
    add_reading(4096, 0);
    add_reading(4032, 0);
    add_reading(4031, 1);
    add_reading(4047, 2);   // held in push inside the band
    add_reading(4048, 3);
    add_reading(1024, 0);
    add_reading(0, 2);      // past full travel, high scale clamps
    add_reading(4160, 1);
    add_reading(4161, 3);
    add_reading(4145, 1);   // held in pull inside the band
    add_reading(4144, 2);
    add_reading(MAX_READING, 1);
    add_reading(100, 0);    // pull straight back to neutral
    wait_drained();

    // zero span on both sides, scale extremes
    write_reg(REG_FULL_PUSH, 4032);
    write_reg(REG_FULL_PULL, 4160);
    write_reg(REG_SCALE_MID, 0);
    write_reg(REG_SCALE_HIGH, 1023);
    release_cfg();
    add_reading(3000, 1);
    add_reading(3000, 2);
    add_reading(5000, 0);
    add_reading(5000, 2);
    add_reading(5000, 1);
    add_reading(4161, 3);
    wait_drained();

    // push edge below zero, negative spans, dropped write to an unused index
    write_reg(REG_CENTER, 10);
    write_reg(REG_DEAD, 4095);
    write_reg(REG_HYST, 4095);
    write_reg(REG_FULL_PUSH, MAX_READING);
    write_reg(REG_FULL_PULL, 0);
    write_reg(REG_UNUSED, 5);
    release_cfg();
    add_reading(0, 0);
    add_reading(5000, 2);
    add_reading(11, 3);
    add_reading(10, 0);
    wait_drained();

    // pull edge above the reading range
    write_reg(REG_CENTER, MAX_READING);
    write_reg(REG_HYST, 0);
    write_reg(REG_FULL_PUSH, 0);
    write_reg(REG_FULL_PULL, MAX_READING);
    release_cfg();
    add_reading(0, 1);
    add_reading(4094, 3);
    add_reading(4095, 0);
    wait_drained();
    n_settings += 4;

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph < 3) begin
        send_idle = 28;
        recv_idle = 57;
      end else if (ph < 6) begin
        send_idle = 57;
        recv_idle = 28;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      apply_setting(ph % 3);
      add_random_readings(HALF_ITEMS);
      if (ph == 1 || ph == 6) hold_reqs++;
      // sender pauses until every pending result is back
      wait_drained();
      add_random_readings(HALF_ITEMS);
      wait_drained();
    end

    repeat (SETTLE_CYC) @(posedge clk);
    $display("covered %0d readings over %0d register settings (%0d writes)",
             n_taken, n_settings, n_cfg);
    $display("results %0d: push %0d, pull %0d, neutral %0d, mismatches %0d",
             n_results, n_push, n_pull, n_results - n_push - n_pull, err_cnt);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results pending", due_bellows_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
